@@ design/pmp_region_table_top_assert.svh @@
// ----------------------------------------------------------------------------
// PMP region table assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef PMP_REGION_TABLE_TOP_ASSERT_SVH
`define PMP_REGION_TABLE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define PRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PRT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PRT_ASSERT(label, prop, msg)

`define PRT_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

@@ design/pmp_rt_pkg.sv @@
// ----------------------------------------------------------------------------
// PMP region table package
// Table size, request/mode/status codes and config byte layout.
// ----------------------------------------------------------------------------
package pmp_rt_pkg;

  localparam int unsigned REGIONS = 4;
  localparam int unsigned RIDX_W  = (REGIONS > 1) ? $clog2(REGIONS) : 1;

  // request codes
  localparam logic [1:0] REQ_SET     = 2'd0;
  localparam logic [1:0] REQ_GET     = 2'd1;
  localparam logic [1:0] REQ_DISABLE = 2'd2;
  localparam logic [1:0] REQ_CLEAR   = 2'd3;

  // requested mode codes
  localparam logic [2:0] MODE_OFF   = 3'd0;
  localparam logic [2:0] MODE_TOR   = 3'd1;
  localparam logic [2:0] MODE_NA4   = 3'd2;
  localparam logic [2:0] MODE_NAPOT = 3'd3;
  localparam logic [2:0] MODE_AUTO  = 3'd4;

  // A field of the config byte
  localparam logic [1:0] A_OFF   = 2'd0;
  localparam logic [1:0] A_TOR   = 2'd1;
  localparam logic [1:0] A_NA4   = 2'd2;
  localparam logic [1:0] A_NAPOT = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_REGION = 3'd1;
  localparam logic [2:0] ST_LOCKED = 3'd2;
  localparam logic [2:0] ST_LEN    = 3'd3;
  localparam logic [2:0] ST_ALIGN  = 3'd4;

  // config byte bit positions
  localparam int unsigned CFG_R_BIT = 0;
  localparam int unsigned CFG_W_BIT = 1;
  localparam int unsigned CFG_X_BIT = 2;
  localparam int unsigned CFG_A_LSB = 3;
  localparam int unsigned CFG_L_BIT = 7;

  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [31:0] NAPOT_MIN = 32'd8;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  region;
    logic [31:0] base_addr;
    logic [31:0] length;
    logic [2:0]  mode;
    logic        rd_perm;
    logic        wr_perm;
    logic        exec_allow;
    logic        lock_req;
  } req_t;

endpackage

@@ design/pmp_region_table_top.sv @@
// ----------------------------------------------------------------------------
// PMP region table
// Holds the PMP config bytes and address words; encodes set requests and
// decodes get requests, one request per cycle while the result side does not stall.
// ----------------------------------------------------------------------------
// Takes one request beat per clock while not stalled and returns one result beat per request.
// A request is captured in an input register; decode, checks and encode run
// in one pass of logic from there into the result register, which drives the
// result beat. The table is updated on the same edge the result is loaded,
// so requests take effect in order. The input side stays open while a
// finished result waits, as long as the input register can move on; a
// stalled result holds at most one more request in the input register.

`include "pmp_region_table_top_assert.svh"

module pmp_region_table_top (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_region,
  input  logic [31:0] in_base_addr,
  input  logic [31:0] in_length,
  input  logic [2:0]  in_mode,
  input  logic        in_rd_perm,
  input  logic        in_wr_perm,
  input  logic        in_exec_allow,
  input  logic        in_lock_req,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_start,
  output logic [31:0] out_length,
  output logic [1:0]  out_mode,
  output logic        out_read,
  output logic        out_write,
  output logic        out_exec,
  output logic        out_lock
);

  localparam int unsigned NREG = pmp_rt_pkg::REGIONS;
  localparam int unsigned IW   = pmp_rt_pkg::RIDX_W;

  // ---------------- handshake ----------------
  logic              item_valid_r;
  pmp_rt_pkg::req_t  item_r;
  logic              out_valid_r;
  logic              out_free;
  logic              advance;
  logic              in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = item_valid_r && out_free;
  assign in_stall = item_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_take) begin
        item_valid_r <= 1'b1;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.req_type   <= in_req_type;
      item_r.region     <= in_region;
      item_r.base_addr  <= in_base_addr;
      item_r.length     <= in_length;
      item_r.mode       <= in_mode;
      item_r.rd_perm    <= in_rd_perm;
      item_r.wr_perm    <= in_wr_perm;
      item_r.exec_allow <= in_exec_allow;
      item_r.lock_req   <= in_lock_req;
    end
  end

  // ---------------- table ----------------
  logic [7:0]  cfg_r    [NREG];
  logic [31:0] addr_r   [NREG];
  logic [7:0]  cfg_nxt  [NREG];
  logic [31:0] addr_nxt [NREG];
  logic [31:0] prev_word [NREG];

  // TOR bottom of each entry is the word of the entry below it
  always_comb begin
    prev_word[0] = '0;
    for (int i = 1; i < NREG; i++) begin
      prev_word[i] = addr_r[i-1];
    end
  end

  logic [IW-1:0] ridx;
  logic          bad_region;
  logic [7:0]    cur_cfg;
  logic [31:0]   cur_word;
  logic [31:0]   cur_prev;
  logic          cur_lock;

  assign ridx       = item_r.region[IW-1:0];
  assign bad_region = {1'b0, item_r.region} >= 5'(NREG);
  assign cur_cfg    = cfg_r[ridx];
  assign cur_word   = addr_r[ridx];
  assign cur_prev   = prev_word[ridx];
  assign cur_lock   = cur_cfg[pmp_rt_pkg::CFG_L_BIT];

  // ---------------- set: mode resolve and encode ----------------
  logic [31:0] len_m1;
  logic        len_pow2;
  logic        word_al;
  logic        len_al;
  logic [2:0]  eff_mode;

  assign len_m1   = item_r.length - 32'd1;
  assign len_pow2 = (item_r.length & len_m1) == '0;
  assign word_al  = item_r.base_addr[1:0] == 2'b00;
  assign len_al   = (item_r.base_addr & len_m1) == '0;

  always_comb begin
    eff_mode = item_r.mode;
    if (item_r.mode == pmp_rt_pkg::MODE_AUTO) begin
      if (item_r.length == '0) begin
        eff_mode = pmp_rt_pkg::MODE_OFF;
      end else if (item_r.length == 32'd4 && word_al) begin
        eff_mode = pmp_rt_pkg::MODE_NA4;
      end else if (item_r.length >= pmp_rt_pkg::NAPOT_MIN && len_pow2 && len_al) begin
        eff_mode = pmp_rt_pkg::MODE_NAPOT;
      end else begin
        eff_mode = pmp_rt_pkg::MODE_TOR;
      end
    end
  end

  logic [2:0]  status;
  logic        set_we;
  logic        clr_one;
  logic        clr_all;
  logic [1:0]  set_a;
  logic [31:0] set_word;
  logic [31:0] tor_top;
  logic [7:0]  set_cfg;

  assign tor_top = item_r.base_addr + item_r.length;

  always_comb begin
    status   = pmp_rt_pkg::ST_OK;
    set_we   = 1'b0;
    clr_one  = 1'b0;
    clr_all  = 1'b0;
    set_a    = pmp_rt_pkg::A_OFF;
    set_word = '0;
    case (item_r.req_type)
      pmp_rt_pkg::REQ_CLEAR: begin
        clr_all = 1'b1;
      end
      default: begin
        if (bad_region) begin
          status = pmp_rt_pkg::ST_REGION;
        end else begin
          case (item_r.req_type)
            pmp_rt_pkg::REQ_SET: begin
              if (cur_lock) begin
                status = pmp_rt_pkg::ST_LOCKED;
              end else begin
                case (eff_mode)
                  pmp_rt_pkg::MODE_OFF: begin
                    set_we = 1'b1;
                  end
                  pmp_rt_pkg::MODE_TOR: begin
                    if (!word_al) begin
                      status = pmp_rt_pkg::ST_ALIGN;
                    end else begin
                      set_we   = 1'b1;
                      set_a    = pmp_rt_pkg::A_TOR;
                      set_word = tor_top >> 2;
                    end
                  end
                  pmp_rt_pkg::MODE_NA4: begin
                    if (!word_al) begin
                      status = pmp_rt_pkg::ST_ALIGN;
                    end else begin
                      set_we   = 1'b1;
                      set_a    = pmp_rt_pkg::A_NA4;
                      set_word = item_r.base_addr >> 2;
                    end
                  end
                  pmp_rt_pkg::MODE_NAPOT: begin
                    if (item_r.length < pmp_rt_pkg::NAPOT_MIN || !len_pow2) begin
                      status = pmp_rt_pkg::ST_LEN;
                    end else if (!len_al) begin
                      status = pmp_rt_pkg::ST_ALIGN;
                    end else begin
                      set_we   = 1'b1;
                      set_a    = pmp_rt_pkg::A_NAPOT;
                      set_word = (item_r.base_addr >> 2) | (len_m1 >> 3);
                    end
                  end
                  default: begin
                    status = pmp_rt_pkg::ST_REGION;
                  end
                endcase
              end
            end
            pmp_rt_pkg::REQ_GET: begin
              status = pmp_rt_pkg::ST_OK;
            end
            default: begin
              if (cur_lock) begin
                status = pmp_rt_pkg::ST_LOCKED;
              end else begin
                clr_one = 1'b1;
              end
            end
          endcase
        end
      end
    endcase
  end

  assign set_cfg = {item_r.lock_req, 2'b00, set_a,
                    item_r.exec_allow, item_r.wr_perm, item_r.rd_perm};

  always_comb begin
    for (int i = 0; i < NREG; i++) begin
      cfg_nxt[i]  = cfg_r[i];
      addr_nxt[i] = addr_r[i];
      if (advance) begin
        if (clr_all && !cfg_r[i][pmp_rt_pkg::CFG_L_BIT]) begin
          cfg_nxt[i]  = '0;
          addr_nxt[i] = '0;
        end
        if (IW'(i) == ridx && clr_one) begin
          cfg_nxt[i]  = '0;
          addr_nxt[i] = '0;
        end
        if (IW'(i) == ridx && set_we) begin
          cfg_nxt[i]  = set_cfg;
          addr_nxt[i] = set_word;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREG; i++) begin
        cfg_r[i]  <= '0;
        addr_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NREG; i++) begin
        cfg_r[i]  <= cfg_nxt[i];
        addr_r[i] <= addr_nxt[i];
      end
    end
  end

  // ---------------- get: decode ----------------
  logic [1:0]  get_a;
  logic [31:0] tor_hi;
  logic [31:0] tor_lo;
  logic [31:0] w_inc;
  logic [31:0] ones_clr;
  logic [31:0] low_zero;
  logic [31:0] get_start;
  logic [31:0] get_len;
  logic        is_get;

  assign get_a  = cur_cfg[pmp_rt_pkg::CFG_A_LSB +: 2];
  assign tor_hi = {cur_word[29:0], 2'b00};
  assign tor_lo = {cur_prev[29:0], 2'b00};
  // w & (w+1) clears the trailing ones; ~w & (w+1) marks the first zero
  assign w_inc    = cur_word + 32'd1;
  assign ones_clr = cur_word & w_inc;
  assign low_zero = ~cur_word & w_inc;
  assign is_get   = item_r.req_type == pmp_rt_pkg::REQ_GET && !bad_region;

  always_comb begin
    get_start = '0;
    get_len   = '0;
    case (get_a)
      pmp_rt_pkg::A_TOR: begin
        get_start = tor_lo;
        get_len   = (tor_hi >= tor_lo) ? (tor_hi - tor_lo) : '0;
      end
      pmp_rt_pkg::A_NA4: begin
        get_start = tor_hi;
        get_len   = 32'd4;
      end
      pmp_rt_pkg::A_NAPOT: begin
        get_start = {ones_clr[29:0], 2'b00};
        get_len   = (&cur_word[28:0]) ? pmp_rt_pkg::ALL_ONES : {low_zero[28:0], 3'b000};
      end
      default: begin
        get_start = '0;
        get_len   = '0;
      end
    endcase
  end

  // ---------------- result register ----------------
  logic [2:0]  out_status_r;
  logic [31:0] out_start_r;
  logic [31:0] out_length_r;
  logic [1:0]  out_mode_r;
  logic        out_read_r;
  logic        out_write_r;
  logic        out_exec_r;
  logic        out_lock_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= status;
      out_start_r  <= is_get ? get_start : '0;
      out_length_r <= is_get ? get_len : '0;
      out_mode_r   <= is_get ? get_a : pmp_rt_pkg::A_OFF;
      out_read_r   <= is_get && cur_cfg[pmp_rt_pkg::CFG_R_BIT];
      out_write_r  <= is_get && cur_cfg[pmp_rt_pkg::CFG_W_BIT];
      out_exec_r   <= is_get && cur_cfg[pmp_rt_pkg::CFG_X_BIT];
      out_lock_r   <= is_get && cur_cfg[pmp_rt_pkg::CFG_L_BIT];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_start  = out_start_r;
  assign out_length = out_length_r;
  assign out_mode   = out_mode_r;
  assign out_read   = out_read_r;
  assign out_write  = out_write_r;
  assign out_exec   = out_exec_r;
  assign out_lock   = out_lock_r;

  // ---------------- assertions ----------------
  for (genvar gi = 0; gi < NREG; gi++) begin : g_lock_chk
    `PRT_ASSERT(a_locked_entry_holds,
      cfg_r[gi][pmp_rt_pkg::CFG_L_BIT] |=>
        (cfg_r[gi] == $past(cfg_r[gi]) && addr_r[gi] == $past(addr_r[gi])),
      "locked PMP entry changed")
  end

  `PRT_ASSERT(a_fail_zero_fields,
    (out_valid_r && out_status_r != pmp_rt_pkg::ST_OK) |->
      (out_start_r == '0 && out_length_r == '0 &&
       out_mode_r == pmp_rt_pkg::A_OFF && !out_lock_r),
    "failed request returned decoded fields")

  `PRT_ASSERT(a_na4_len,
    (out_valid_r && out_mode_r == pmp_rt_pkg::A_NA4) |-> out_length_r == 32'd4,
    "NA4 decode length is not four")

  `PRT_ASSERT(a_item_kept,
    (item_valid_r && !advance) |=> item_valid_r,
    "held request dropped from input register")

endmodule

@@ dv/pmp_shadow_pkg.sv @@
// ----------------------------------------------------------------------------
// PMP region table shadow
// Shadow copy of the region table that predicts each result beat, and the
// queue of results still owed by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmp_shadow_pkg;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] base;
    logic [31:0] size;
    logic [1:0]  mode;
    logic        rd;
    logic        wr;
    logic        ex;
    logic        lk;
  } pmp_result_t;

  class pmp_shadow_table;
    logic [7:0]  shadow_cfg  [pmp_rt_pkg::REGIONS];
    logic [31:0] shadow_addr [pmp_rt_pkg::REGIONS];
    pmp_result_t pending_results [$];
    int unsigned mismatches;

    function new();
      foreach (shadow_cfg[i]) begin
        shadow_cfg[i]  = '0;
        shadow_addr[i] = '0;
      end
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void note_mismatch(string msg);
      if (mismatches < 10) $display("%s", msg);
      mismatches++;
    endfunction

    // Apply one accepted request to the shadow table and queue its result.
    function void note_request(pmp_rt_pkg::req_t q);
      pmp_result_t exp_r;
      int unsigned idx;
      int unsigned t;
      logic [2:0]  m;
      logic [1:0]  a;
      logic [7:0]  c;
      logic [31:0] word, top, bot, mask;
      logic [31:0] len_m1;
      logic        len_pow2, word_al, len_al;
      exp_r = '0;
      idx = 32'(q.region);
      len_m1   = q.length - 32'd1;
      len_pow2 = (q.length & len_m1) == 32'd0;
      word_al  = q.base_addr[1:0] == 2'b00;
      len_al   = (q.base_addr & len_m1) == 32'd0;
      if (q.req_type == pmp_rt_pkg::REQ_CLEAR) begin
        for (int i = 0; i < pmp_rt_pkg::REGIONS; i++) begin
          if (!shadow_cfg[i][pmp_rt_pkg::CFG_L_BIT]) begin
            shadow_cfg[i]  = '0;
            shadow_addr[i] = '0;
          end
        end
      end else if (idx >= pmp_rt_pkg::REGIONS) begin
        exp_r.status = pmp_rt_pkg::ST_REGION;
      end else if (q.req_type != pmp_rt_pkg::REQ_GET &&
                   shadow_cfg[idx][pmp_rt_pkg::CFG_L_BIT]) begin
        // lock wins over every set check but the region check, invalid mode included
        exp_r.status = pmp_rt_pkg::ST_LOCKED;
      end else if (q.req_type == pmp_rt_pkg::REQ_DISABLE) begin
        shadow_cfg[idx]  = '0;
        shadow_addr[idx] = '0;
      end else if (q.req_type == pmp_rt_pkg::REQ_SET) begin
        m = q.mode;
        word = '0;
        if (m == pmp_rt_pkg::MODE_AUTO) begin
          if (q.length == 32'd0)
            m = pmp_rt_pkg::MODE_OFF;
          else if (q.length == 32'd4 && word_al)
            m = pmp_rt_pkg::MODE_NA4;
          else if (q.length >= pmp_rt_pkg::NAPOT_MIN && len_pow2 && len_al)
            m = pmp_rt_pkg::MODE_NAPOT;
          else
            m = pmp_rt_pkg::MODE_TOR;
        end
        case (m)
          pmp_rt_pkg::MODE_OFF: word = '0;
          pmp_rt_pkg::MODE_TOR: begin
            if (!word_al) exp_r.status = pmp_rt_pkg::ST_ALIGN;
            else word = (q.base_addr + q.length) >> 2;
          end
          pmp_rt_pkg::MODE_NA4: begin
            if (!word_al) exp_r.status = pmp_rt_pkg::ST_ALIGN;
            else word = q.base_addr >> 2;
          end
          pmp_rt_pkg::MODE_NAPOT: begin
            if (q.length < pmp_rt_pkg::NAPOT_MIN || !len_pow2)
              exp_r.status = pmp_rt_pkg::ST_LEN;
            else if (!len_al)
              exp_r.status = pmp_rt_pkg::ST_ALIGN;
            else
              word = (q.base_addr >> 2) | (len_m1 >> 3);
          end
          default: exp_r.status = pmp_rt_pkg::ST_REGION;
        endcase
        if (exp_r.status == pmp_rt_pkg::ST_OK) begin
          c = '0;
          c[pmp_rt_pkg::CFG_R_BIT] = q.rd_perm;
          c[pmp_rt_pkg::CFG_W_BIT] = q.wr_perm;
          c[pmp_rt_pkg::CFG_X_BIT] = q.exec_allow;
          c[pmp_rt_pkg::CFG_L_BIT] = q.lock_req;
          c[pmp_rt_pkg::CFG_A_LSB +: 2] = m[1:0];
          shadow_cfg[idx]  = c;
          shadow_addr[idx] = word;
        end
      end else begin
        c = shadow_cfg[idx];
        word = shadow_addr[idx];
        a = c[pmp_rt_pkg::CFG_A_LSB +: 2];
        case (a)
          pmp_rt_pkg::A_TOR: begin
            // bottom comes from the previous entry, whatever its mode
            top = word << 2;
            bot = (idx == 0) ? 32'd0 : (shadow_addr[idx - 1] << 2);
            exp_r.base = bot;
            exp_r.size = (top >= bot) ? (top - bot) : 32'd0;
          end
          pmp_rt_pkg::A_NA4: begin
            exp_r.base = word << 2;
            exp_r.size = 32'd4;
          end
          pmp_rt_pkg::A_NAPOT: begin
            t = 0;
            while (t < 32 && word[t]) t++;
            mask = (t >= 32) ? pmp_rt_pkg::ALL_ONES : ((32'd1 << t) - 32'd1);
            exp_r.size = (t >= 29) ? pmp_rt_pkg::ALL_ONES : (32'd1 << (t + 3));
            exp_r.base = (word & ~mask) << 2;
          end
          default: ;
        endcase
        exp_r.mode = a;
        exp_r.rd = c[pmp_rt_pkg::CFG_R_BIT];
        exp_r.wr = c[pmp_rt_pkg::CFG_W_BIT];
        exp_r.ex = c[pmp_rt_pkg::CFG_X_BIT];
        exp_r.lk = c[pmp_rt_pkg::CFG_L_BIT];
      end
      pending_results.push_back(exp_r);
    endfunction

    function void check_result(pmp_result_t act);
      pmp_result_t exp_r;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result beat: status %0d base %h size %h",
                                act.status, act.base, act.size));
        return;
      end
      exp_r = pending_results.pop_front();
      if (act.status !== exp_r.status || act.base !== exp_r.base ||
          act.size !== exp_r.size || act.mode !== exp_r.mode ||
          act.rd !== exp_r.rd || act.wr !== exp_r.wr ||
          act.ex !== exp_r.ex || act.lk !== exp_r.lk)
        note_mismatch({
          $sformatf("result mismatch: exp st %0d base %h size %h mode %0d rwxl %b%b%b%b",
                    exp_r.status, exp_r.base, exp_r.size, exp_r.mode,
                    exp_r.rd, exp_r.wr, exp_r.ex, exp_r.lk),
          $sformatf(" | act st %0d base %h size %h mode %0d rwxl %b%b%b%b",
                    act.status, act.base, act.size, act.mode,
                    act.rd, act.wr, act.ex, act.lk)});
    endfunction
  endclass

endpackage

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// PMP region table testbench
// Directed set/get/disable/clear requests, then random well-formed and broken
// region programming, with random gaps and stalls on both channels; every
// result beat is checked against a shadow table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned RANDOM_ITEMS   = 2000;
  localparam int unsigned WATCHDOG_LIMIT = 200;
  localparam int unsigned TAIL_CYCLES    = 10;
  localparam logic [3:0]  LOCKABLE_REGION = 4'd2;
  localparam logic [2:0]  MODE_BAD_LO    = 3'd5;
  localparam logic [2:0]  MODE_BAD_HI    = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [3:0]  in_region;
  logic [31:0] in_base_addr;
  logic [31:0] in_length;
  logic [2:0]  in_mode;
  logic        in_rd_perm;
  logic        in_wr_perm;
  logic        in_exec_allow;
  logic        in_lock_req;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [31:0] out_start;
  logic [31:0] out_length;
  logic [1:0]  out_mode;
  logic        out_read;
  logic        out_write;
  logic        out_exec;
  logic        out_lock;

  pmp_shadow_pkg::pmp_shadow_table shadow = new();
  bit               no_idle;
  int unsigned      quiet_cycles;
  pmp_rt_pkg::req_t directed [$];

  pmp_region_table_top DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic pmp_rt_pkg::req_t mk_req(logic [1:0] rt, logic [3:0] rg,
                                              logic [31:0] sa, logic [31:0] ln,
                                              logic [2:0] md, logic [3:0] lxwr);
    pmp_rt_pkg::req_t q;
    q = '{req_type: rt, region: rg, base_addr: sa, length: ln, mode: md,
          rd_perm: lxwr[0], wr_perm: lxwr[1], exec_allow: lxwr[2],
          lock_req: lxwr[3]};
    return q;
  endfunction

  function automatic pmp_rt_pkg::req_t random_req();
    pmp_rt_pkg::req_t q;
    int unsigned sel;
    logic [31:0] len;
    sel = $urandom_range(0, 99);
    q.req_type = (sel < 50) ? pmp_rt_pkg::REQ_SET : (sel < 85) ? pmp_rt_pkg::REQ_GET :
                 (sel < 97) ? pmp_rt_pkg::REQ_DISABLE : pmp_rt_pkg::REQ_CLEAR;
    q.region = ($urandom_range(0, 99) < 88) ?
               4'($urandom_range(0, pmp_rt_pkg::REGIONS - 1)) :
               4'($urandom_range(pmp_rt_pkg::REGIONS, 15));
    q.base_addr  = $urandom;
    q.length     = $urandom;
    q.mode       = 3'($urandom_range(0, 7));
    q.rd_perm    = 1'($urandom_range(0, 1));
    q.wr_perm    = 1'($urandom_range(0, 1));
    q.exec_allow = 1'($urandom_range(0, 1));
    q.lock_req   = 1'($urandom_range(0, 1));
    if (q.req_type == pmp_rt_pkg::REQ_SET && q.region < pmp_rt_pkg::REGIONS) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        len = 32'd1 << $urandom_range(3, 31);
        q.length = len;
        q.base_addr = q.base_addr & ~(len - 32'd1);
        q.mode = $urandom_range(0, 1) ? pmp_rt_pkg::MODE_NAPOT : pmp_rt_pkg::MODE_AUTO;
      end else if (sel < 45) begin
        q.length = 32'd4;
        q.base_addr[1:0] = 2'b00;
        q.mode = $urandom_range(0, 1) ? pmp_rt_pkg::MODE_NA4 : pmp_rt_pkg::MODE_AUTO;
      end else if (sel < 70) begin
        q.base_addr[1:0] = 2'b00;
        if ($urandom_range(0, 3) != 0) q.length = $urandom_range(0, 32'h0010_0000);
        q.mode = $urandom_range(0, 1) ? pmp_rt_pkg::MODE_TOR : pmp_rt_pkg::MODE_AUTO;
      end else if (sel < 78) begin
        if ($urandom_range(0, 1)) begin
          q.mode = pmp_rt_pkg::MODE_OFF;
        end else begin
          q.mode = pmp_rt_pkg::MODE_AUTO;
          q.length = 32'd0;
        end
      end else if (sel < 88) begin
        // broken: bad NAPOT size or a start off its alignment
        if ($urandom_range(0, 1)) begin
          q.mode = pmp_rt_pkg::MODE_NAPOT;
          q.length = $urandom_range(0, 40);
        end else begin
          len = 32'd1 << $urandom_range(3, 20);
          q.mode = 3'($urandom_range(pmp_rt_pkg::MODE_TOR, pmp_rt_pkg::MODE_NAPOT));
          q.length = len;
          q.base_addr = (q.base_addr & ~(len - 32'd1)) | $urandom_range(1, 3);
        end
      end
      // keep most entries writable for the whole run
      q.lock_req = (q.region == LOCKABLE_REGION) && ($urandom_range(0, 199) == 0);
    end
    return q;
  endfunction

  // Leaves in_valid high after the beat so back-to-back beats need no gap.
  task automatic send_req(pmp_rt_pkg::req_t q);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_req_type, in_region, in_base_addr, in_length, in_mode,
     in_rd_perm, in_wr_perm, in_exec_allow, in_lock_req} <= q;
    do @(posedge clk); while (in_stall !== 1'b0);
    shadow.note_request(q);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0);
  endtask

  initial begin : result_sink
    int unsigned hold;
    pmp_shadow_pkg::pmp_result_t act;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 3);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n === 1'b1 && out_valid === 1'b1));
      act = '{status: out_status, base: out_start, size: out_length, mode: out_mode,
              rd: out_read, wr: out_write, ex: out_exec, lk: out_lock};
      shadow.check_result(act);
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_req_type   <= pmp_rt_pkg::REQ_GET;
    in_region     <= '0;
    in_base_addr  <= '0;
    in_length     <= '0;
    in_mode       <= pmp_rt_pkg::MODE_OFF;
    in_rd_perm    <= 1'b0;
    in_wr_perm    <= 1'b0;
    in_exec_allow <= 1'b0;
    in_lock_req   <= 1'b0;

    directed.push_back(mk_req(pmp_rt_pkg::REQ_GET, 0, 0, 0, pmp_rt_pkg::MODE_OFF, 4'b0000));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_SET, 0, 32'h0000_1000, 32'd4,
                              pmp_rt_pkg::MODE_NA4, 4'b0111));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_SET, 1, 32'h0000_1004, 32'h0000_0FFC,
                              pmp_rt_pkg::MODE_TOR, 4'b0011));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_GET, 1, 0, 0, pmp_rt_pkg::MODE_OFF, 4'b0000));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_SET, 2, 32'h8000_0000, 32'h8000_0000,
                              pmp_rt_pkg::MODE_AUTO, 4'b0101));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_GET, 2, 0, 0, pmp_rt_pkg::MODE_OFF, 4'b0000));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_SET, 1, 32'hFFFF_FFF8, 32'd8,
                              pmp_rt_pkg::MODE_NAPOT, 4'b0001));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_SET, 1, 32'h0, 32'd12,
                              pmp_rt_pkg::MODE_NAPOT, 4'b0001));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_SET, 1, 32'h10, 32'h20,
                              pmp_rt_pkg::MODE_NAPOT, 4'b0001));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_SET, 0, 32'h2, 32'd4,
                              pmp_rt_pkg::MODE_NA4, 4'b0001));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_SET, 0, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                              pmp_rt_pkg::MODE_AUTO, 4'b0111));
    // TOR top wraps past 2^32
    directed.push_back(mk_req(pmp_rt_pkg::REQ_SET, 0, 32'hFFFF_FFF0, 32'h20,
                              pmp_rt_pkg::MODE_TOR, 4'b0110));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_GET, 0, 0, 0, pmp_rt_pkg::MODE_OFF, 4'b0000));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_SET, 1, 32'h0, 32'd0,
                              pmp_rt_pkg::MODE_AUTO, 4'b0111));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_GET, 1, 0, 0, pmp_rt_pkg::MODE_OFF, 4'b0000));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_SET, 2, 32'h1234_5678, 32'hDEAD_BEEF,
                              pmp_rt_pkg::MODE_OFF, 4'b0010));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_SET, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              MODE_BAD_HI, 4'b1111));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_SET, 15, 32'h0, 32'd4,
                              pmp_rt_pkg::MODE_NA4, 4'b1111));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_GET, 4, 0, 0, pmp_rt_pkg::MODE_OFF, 4'b0000));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_DISABLE, 9, 0, 0,
                              pmp_rt_pkg::MODE_OFF, 4'b0000));
    // lock region 3; its top lands above the bottom from region 2
    directed.push_back(mk_req(pmp_rt_pkg::REQ_SET, 3, 32'h0, 32'h1000,
                              pmp_rt_pkg::MODE_TOR, 4'b1001));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_GET, 3, 0, 0, pmp_rt_pkg::MODE_OFF, 4'b0000));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_SET, 3, 32'h0, 32'd4, MODE_BAD_LO, 4'b0001));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_DISABLE, 3, 0, 0,
                              pmp_rt_pkg::MODE_OFF, 4'b0000));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_DISABLE, 0, 0, 0,
                              pmp_rt_pkg::MODE_OFF, 4'b0000));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_CLEAR, 12, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              MODE_BAD_HI, 4'b1111));
    directed.push_back(mk_req(pmp_rt_pkg::REQ_GET, 3, 0, 0, pmp_rt_pkg::MODE_OFF, 4'b0000));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_req(directed[i]);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = ((i / 200) % 4 == 3);
      if (i == RANDOM_ITEMS / 2) drain_results();
      send_req(random_req());
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (shadow.mismatches == 0 && shadow.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
